### rtl/pbd_pkg.sv
// Shared types, constants and register map for the power button debouncer.
package pbd_pkg;

    localparam int CFG_TICK_BITS      = 20;
    localparam int COUNT_BITS_DEFAULT = 20;
    localparam int APB_ADDR_BITS      = 5;
    localparam int APB_DATA_BITS      = 32;
    localparam int IN_DATA_BITS       = 8;
    localparam int OUT_DATA_BITS      = 8;

    localparam logic [CFG_TICK_BITS-1:0] DEBOUNCE_TICKS_RST         = 20'd30000;
    localparam logic [CFG_TICK_BITS-1:0] FACTORY_DEBOUNCE_TICKS_RST = 20'd600000;
    localparam logic [CFG_TICK_BITS-1:0] WAKE_DEBOUNCE_TICKS_RST    = 20'd5000;

    typedef enum logic [2:0] {
        REG_DEBOUNCE_TICKS         = 3'd0,
        REG_FACTORY_DEBOUNCE_TICKS = 3'd1,
        REG_FACTORY_TEST_ENABLE    = 3'd2,
        REG_ACTIVE_HIGH            = 3'd3,
        REG_IGNORE_LID             = 3'd4,
        REG_WAKE_DEBOUNCE_TICKS    = 3'd5,
        REG_WAKE_ENABLE            = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_TICK_BITS-1:0] debounce_ticks;
        logic [CFG_TICK_BITS-1:0] factory_debounce_ticks;
        logic                     factory_test_enable;
        logic                     active_high;
        logic                     ignore_lid;
        logic [CFG_TICK_BITS-1:0] wake_debounce_ticks;
        logic                     wake_enable;
    } cfg_t;

    // Packed MSB first, so the last member lands in bit 0.
    typedef struct packed {
        logic wake_query;
        logic wlan_wake_n;
        logic lan_wake_n;
        logic chipset_on;
        logic simulate_press;
        logic power_lock;
        logic lid_open;
        logic button_level;
    } in_item_t;

    typedef struct packed {
        logic pad;
        logic wake_answer;
        logic wake_event;
        logic keyscan_disabled;
        logic host_press_event;
        logic change_event;
        logic stable;
        logic pressed;
    } out_item_t;

endpackage

### rtl/pbd_regs.sv
// APB configuration register file for the power button debouncer.
module pbd_regs
    import pbd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_DEBOUNCE_TICKS:
                    cfg_next.debounce_ticks = pwdata[CFG_TICK_BITS-1:0];
                REG_FACTORY_DEBOUNCE_TICKS:
                    cfg_next.factory_debounce_ticks = pwdata[CFG_TICK_BITS-1:0];
                REG_FACTORY_TEST_ENABLE:
                    cfg_next.factory_test_enable = pwdata[0];
                REG_ACTIVE_HIGH:
                    cfg_next.active_high = pwdata[0];
                REG_IGNORE_LID:
                    cfg_next.ignore_lid = pwdata[0];
                REG_WAKE_DEBOUNCE_TICKS:
                    cfg_next.wake_debounce_ticks = pwdata[CFG_TICK_BITS-1:0];
                REG_WAKE_ENABLE:
                    cfg_next.wake_enable = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DEBOUNCE_TICKS:
                prdata = APB_DATA_BITS'(cfg_reg.debounce_ticks);
            REG_FACTORY_DEBOUNCE_TICKS:
                prdata = APB_DATA_BITS'(cfg_reg.factory_debounce_ticks);
            REG_FACTORY_TEST_ENABLE:
                prdata = APB_DATA_BITS'(cfg_reg.factory_test_enable);
            REG_ACTIVE_HIGH:
                prdata = APB_DATA_BITS'(cfg_reg.active_high);
            REG_IGNORE_LID:
                prdata = APB_DATA_BITS'(cfg_reg.ignore_lid);
            REG_WAKE_DEBOUNCE_TICKS:
                prdata = APB_DATA_BITS'(cfg_reg.wake_debounce_ticks);
            REG_WAKE_ENABLE:
                prdata = APB_DATA_BITS'(cfg_reg.wake_enable);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks         <= DEBOUNCE_TICKS_RST;
            cfg_reg.factory_debounce_ticks <= FACTORY_DEBOUNCE_TICKS_RST;
            cfg_reg.factory_test_enable    <= 1'b0;
            cfg_reg.active_high            <= 1'b0;
            cfg_reg.ignore_lid             <= 1'b0;
            cfg_reg.wake_debounce_ticks    <= WAKE_DEBOUNCE_TICKS_RST;
            cfg_reg.wake_enable            <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/pbd_timer.sv
// Restartable debounce countdown that expires in the tick it reaches zero.
module pbd_timer
    import pbd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     load,
    input  logic [CFG_TICK_BITS-1:0] delay,
    output logic                     expire
);

    localparam int LOAD_BITS = (COUNT_BITS > CFG_TICK_BITS) ? COUNT_BITS : CFG_TICK_BITS;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  armed_reg;
    logic                  armed_next;
    logic [LOAD_BITS-1:0]  delay_ext;
    logic [LOAD_BITS-1:0]  max_ext;
    logic [LOAD_BITS-1:0]  sat_ext;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  cur_armed;

    // Delays beyond the counter range saturate at its maximum.
    assign delay_ext = LOAD_BITS'(delay);
    assign max_ext   = LOAD_BITS'({COUNT_BITS{1'b1}});
    assign sat_ext   = (delay_ext > max_ext) ? max_ext : delay_ext;

    assign cur_count = load ? sat_ext[COUNT_BITS-1:0] : count_reg;
    assign cur_armed = load || armed_reg;
    assign expire    = step && cur_armed && (cur_count == '0);

    always_comb
    begin
        count_next = count_reg;
        armed_next = armed_reg;
        if (step)
        begin
            count_next = cur_count;
            armed_next = cur_armed;
            if (cur_armed)
            begin
                if (cur_count == '0)
                begin
                    armed_next = 1'b0;
                end
                else
                begin
                    count_next = cur_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            armed_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            armed_reg <= armed_next;
        end
    end

endmodule

### rtl/power_button_debouncer.sv
// Power button and wake pin debouncer, top level.
// Path: an accepted beat waits in the input register and moves to the result register once that is free or drained.
// Throughput: one beat per cycle unless the output stalls; the input and result registers
// each hold one beat, so a stalled output still lets one more beat in.
// Reset: asynchronous, active low; returns the handshake, debounce and config state to reset values.
// The first beat after reset seeds the last-level history and sees no edge.
module power_button_debouncer
    import pbd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [0] button_level [1] lid_open [2] power_lock [3] simulate_press
    // [4] chipset_on [5] lan_wake_n [6] wlan_wake_n [7] wake_query
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [0] pressed [1] stable [2] change_event [3] host_press_event
    // [4] keyscan_disabled [5] wake_event [6] wake_answer [7] zero
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      out_valid_reg;
    logic      advance;
    logic      s_accept;

    logic      deb_reg, stable_reg, init_reg, last_lvl_reg, last_sim_reg, hold_reg;
    logic      deb_next, stable_next, hold_next;
    logic [1:0] last_wake_reg;
    logic [1:0] latch_reg;
    logic [1:0] latch_next;

    logic      first;
    logic      raw;
    logic      deb_a, stable_a, hold_a;
    logic      last_lvl, last_sim;
    logic [1:0] last_wake;
    logic [1:0] wlev;
    logic [1:0] latch_a;
    logic [1:0] latch_b;
    logic      btn_edge, sim_chg, btn_load, btn_expire;
    logic [CFG_TICK_BITS-1:0] btn_delay;
    logic [1:0] wake_edge;
    logic [1:0] wake_expire;
    logic      chg, wev, ans;

    pbd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_item_reg;

    assign first = !init_reg;
    assign wlev  = {in_item_reg.wlan_wake_n, in_item_reg.lan_wake_n};

    always_comb
    begin
        if (in_item_reg.simulate_press)
        begin
            raw = 1'b1;
        end
        else if (in_item_reg.power_lock || (!cfg.ignore_lid && !in_item_reg.lid_open))
        begin
            raw = 1'b0;
        end
        else
        begin
            raw = (in_item_reg.button_level == cfg.active_high);
        end
    end

    assign deb_a     = (first && raw) ? 1'b1 : deb_reg;
    assign last_lvl  = first ? in_item_reg.button_level : last_lvl_reg;
    assign last_sim  = first ? in_item_reg.simulate_press : last_sim_reg;
    assign last_wake = first ? wlev : last_wake_reg;
    assign latch_a   = first ? 2'b00 : latch_reg;

    assign btn_edge  = in_item_reg.button_level != last_lvl;
    assign sim_chg   = in_item_reg.simulate_press != last_sim;
    assign btn_load  = btn_edge || sim_chg;
    assign hold_a    = (btn_edge && raw) ? 1'b1 : hold_reg;
    assign stable_a  = btn_load ? 1'b0 : stable_reg;

    // A simulate change forces an immediate evaluation.
    always_comb
    begin
        if (sim_chg)
        begin
            btn_delay = '0;
        end
        else if (cfg.factory_test_enable && in_item_reg.chipset_on)
        begin
            btn_delay = cfg.factory_debounce_ticks;
        end
        else
        begin
            btn_delay = cfg.debounce_ticks;
        end
    end

    pbd_timer #(
        .COUNT_BITS (COUNT_BITS)
    ) u_btn_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .load   (btn_load),
        .delay  (btn_delay),
        .expire (btn_expire)
    );

    assign wake_edge = wlev ^ last_wake;

    for (genvar g = 0; g < 2; g++)
    begin : g_wake
        pbd_timer #(
            .COUNT_BITS (COUNT_BITS)
        ) u_wake_timer (
            .clk    (clk),
            .rst_n  (rst_n),
            .step   (advance),
            .load   (wake_edge[g]),
            .delay  (cfg.wake_debounce_ticks),
            .expire (wake_expire[g])
        );
    end

    assign deb_next    = btn_expire ? raw : deb_a;
    assign chg         = btn_expire && (raw != deb_a);
    assign hold_next   = (btn_expire && !raw) ? 1'b0 : hold_a;
    assign stable_next = btn_expire ? 1'b1 : stable_a;

    assign latch_b    = latch_a | (wake_expire & ~wlev);
    assign wev        = |(wake_expire & ~wlev);
    assign ans        = in_item_reg.wake_query && cfg.wake_enable && (|latch_b);
    assign latch_next = ans ? 2'b00 : latch_b;

    always_comb
    begin
        out_item_next.pad              = 1'b0;
        out_item_next.wake_answer      = ans;
        out_item_next.wake_event       = wev;
        out_item_next.keyscan_disabled = hold_next;
        out_item_next.host_press_event = chg && raw;
        out_item_next.change_event     = chg;
        out_item_next.stable           = stable_next;
        out_item_next.pressed          = deb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            deb_reg       <= 1'b0;
            stable_reg    <= 1'b1;
            init_reg      <= 1'b0;
            last_lvl_reg  <= 1'b0;
            last_sim_reg  <= 1'b0;
            hold_reg      <= 1'b0;
            last_wake_reg <= 2'b11;
            latch_reg     <= 2'b00;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                deb_reg       <= deb_next;
                stable_reg    <= stable_next;
                init_reg      <= 1'b1;
                last_lvl_reg  <= in_item_reg.button_level;
                last_sim_reg  <= in_item_reg.simulate_press;
                hold_reg      <= hold_next;
                last_wake_reg <= wlev;
                latch_reg     <= latch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("result register not loaded after advance");

    a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input register empty but not ready");

    a_press_event_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[0] == m_axis_tdata[3]))
        else $error("host press event disagrees with debounced state");

    a_answer_clears_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ans) |=> (latch_reg == 2'b00))
        else $error("wake latches not cleared after answer");

endmodule
